// ----- rtl/fao_pkg.sv -----
// ----------------------------------------------------------------------------
// fao_pkg
// shared widths, angle constants and pipeline word types for the
// octant arctangent approximation
// ----------------------------------------------------------------------------
package fao_pkg;

   // port width of each vector component
   localparam int FIELD_W        = 24;
   // bits of each component that are used, read as a signed value (8..24)
   localparam int IN_WIDTH       = 24;
   // magnitude after saturation of the most negative code
   localparam int MAG_W          = IN_WIDTH - 1;
   // partial remainder of the divider, one bit of headroom for the shift
   localparam int REM_W          = MAG_W + 1;
   // fraction bits of min/max (scale 256)
   localparam int FRAC_BITS      = 8;
   // quotient bits resolved per divider stage
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = FRAC_BITS / BITS_PER_STAGE;
   // result angle width, 1024 equals pi
   localparam int OUT_W          = 12;

   localparam logic [OUT_W-1:0] ANGLE_HALF_PI = OUT_W'(512);
   localparam logic [OUT_W-1:0] ANGLE_PI      = OUT_W'(1024);

   // octant decisions carried alongside the divider
   typedef struct packed {
      logic zero;    // both components zero
      logic swap;    // |y| > |x|
      logic x_neg;
      logic y_neg;
      logic q_top;   // quotient msb: min equals max
   } oct_flags_type;

   typedef struct packed {
      logic [REM_W-1:0]     rem;
      logic [MAG_W-1:0]     hi;
      logic [FRAC_BITS-1:0] q;
      oct_flags_type        flags;
   } div_word_type;

endpackage

// ----- rtl/fast_atan2_octant.sv -----
// ----------------------------------------------------------------------------
// fast_atan2_octant
// approximate four-quadrant arctangent: linear estimate min*256/max over
// the first octant, mirrored into the octant of (cos, sin)
// ----------------------------------------------------------------------------
//
//   channel  ports                              direction  word
//   req      req_valid/req_ready,               in         one vector pair
//            req_sin_val, req_cos_val
//   rsp      rsp_valid/rsp_ready, rsp_angle     out        one angle, pi = 1024
//
// - stage 1, divider stages, output register; a word per cycle unless rsp stalls
// - the four divider stages, two quotient bits each, set the pipeline depth
// - reset clears only the stage valid bits, data registers are not reset
// - a stall on rsp freezes every stage at once; req_ready falls in the same
//   cycle, so no word is dropped or repeated
//
module fast_atan2_octant
   import fao_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [FIELD_W-1:0] req_sin_val,
   input  logic signed [FIELD_W-1:0] req_cos_val,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [OUT_W-1:0]   rsp_angle
);

   // magnitude of the low IN_WIDTH bits, most negative code saturated
   function automatic logic [MAG_W-1:0] comp_mag(input logic [FIELD_W-1:0] raw);
      logic [IN_WIDTH-1:0] v;
      logic [IN_WIDTH-1:0] neg;
      v   = raw[IN_WIDTH-1:0];
      neg = ~v + IN_WIDTH'(1);
      if (!v[IN_WIDTH-1]) begin
         comp_mag = v[MAG_W-1:0];
      end else if (v[MAG_W-1:0] == '0) begin
         comp_mag = '1;
      end else begin
         comp_mag = neg[MAG_W-1:0];
      end
   endfunction

   // output register valid bit
   logic rsp_valid_ff;

   // whole pipeline advances together
   logic enable;
   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;

   // ---------------------------------------------------------------------
   // stage 1: magnitudes, octant flags, min/max and the quotient msb
   // ---------------------------------------------------------------------
   logic         s1_valid_ff;
   div_word_type s1_word_ff;
   div_word_type s1_word_in;

   always_comb begin
      logic [MAG_W-1:0] ay;
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] lo;
      ay = comp_mag(req_sin_val);
      ax = comp_mag(req_cos_val);
      s1_word_in.flags.swap  = ay > ax;
      s1_word_in.flags.x_neg = req_cos_val[IN_WIDTH-1];
      s1_word_in.flags.y_neg = req_sin_val[IN_WIDTH-1];
      s1_word_in.flags.zero  = (ay == '0) && (ax == '0);
      lo                     = (ay > ax) ? ax : ay;
      s1_word_in.hi          = (ay > ax) ? ay : ax;
      // lo never exceeds hi: the top quotient bit is set only when equal
      s1_word_in.flags.q_top = lo == s1_word_in.hi;
      s1_word_in.rem         = s1_word_in.flags.q_top ? '0 : {1'b0, lo};
      s1_word_in.q           = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_word_ff <= s1_word_in;
      end
   end

   // ---------------------------------------------------------------------
   // divider stages: remaining eight fraction bits
   // ---------------------------------------------------------------------
   logic         div_valid [DIV_STAGES+1];
   div_word_type div_word  [DIV_STAGES+1];

   assign div_valid[0] = s1_valid_ff;
   assign div_word[0]  = s1_word_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      fao_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (div_valid[g]),
         .in_word   (div_word[g]),
         .out_valid (div_valid[g+1]),
         .out_word  (div_word[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // last stage: octant mirroring into the output register
   // ---------------------------------------------------------------------
   div_word_type            last_word;
   logic [OUT_W-1:0]        rsp_angle_ff;
   logic [OUT_W-1:0]        rsp_angle_in;

   assign last_word = div_word[DIV_STAGES];

   always_comb begin
      logic [OUT_W-1:0] a;
      a = OUT_W'({last_word.flags.q_top, last_word.q});
      if (last_word.flags.swap) begin
         a = ANGLE_HALF_PI - a;
      end
      if (last_word.flags.x_neg) begin
         a = ANGLE_PI - a;
      end
      if (last_word.flags.y_neg) begin
         a = ~a + OUT_W'(1);
      end
      rsp_angle_in = last_word.flags.zero ? '0 : a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_angle_ff <= rsp_angle_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = $signed(rsp_angle_ff);

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------

   // the angle never leaves -pi..pi
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_angle) <= $signed(ANGLE_PI)) &&
                    ($signed(rsp_angle) >= -$signed(ANGLE_PI)))
      else $error("angle out of range");

   // equal magnitudes leave no remainder and no fraction bits
   a_top_exact: assert property (@(posedge clock) disable iff (reset)
      div_valid[DIV_STAGES] && last_word.flags.q_top && !last_word.flags.zero
      |-> (last_word.rem == '0) && (last_word.q == '0))
      else $error("quotient msb with nonzero remainder");

   // restoring divider keeps its remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      div_valid[DIV_STAGES] && !last_word.flags.zero
      |-> last_word.rem < {1'b0, last_word.hi})
      else $error("divider remainder not below divisor");

   // a stalled pipeline does not alter the presented angle
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle))
      else $error("output changed during stall");

endmodule

// ----- rtl/fao_div_stage.sv -----
// ----------------------------------------------------------------------------
// fao_div_stage
// one registered stage of the restoring divider, resolving
// BITS_PER_STAGE quotient bits of min*256/max
// ----------------------------------------------------------------------------
module fao_div_stage
   import fao_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         in_valid,
   input  div_word_type in_word,
   output logic         out_valid,
   output div_word_type out_word
);

   logic         out_valid_ff;
   div_word_type word_ff;
   div_word_type word_in;

   always_comb begin
      logic [REM_W-1:0] r;
      logic [REM_W-1:0] d;
      word_in = in_word;
      r = in_word.rem;
      d = {1'b0, in_word.hi};
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
         // remainder stays below hi, so the shift fits
         r = {r[REM_W-2:0], 1'b0};
         if (r >= d) begin
            r = r - d;
            word_in.q = {word_in.q[FRAC_BITS-2:0], 1'b1};
         end else begin
            word_in.q = {word_in.q[FRAC_BITS-2:0], 1'b0};
         end
      end
      word_in.rem = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the octant arctangent approximation: a directed
// table of corner vectors and then random vector pairs, each angle checked
// against its table angle or an in-bench predictor, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top
   import fao_pkg::*;
();

   localparam int RAND_WORDS      = 1250;
   localparam int HOLD_AT         = 300;   // receiver starts one long hold-off at this word
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int DRAIN_AT        = 700;   // sender waits for every angle here
   localparam int QUIET_FROM      = 800;   // no idling on either side in this span
   localparam int QUIET_TO        = 1000;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 12;

   localparam logic signed [FIELD_W-1:0] COMP_MAX  = FIELD_W'((1 << (IN_WIDTH - 1)) - 1);
   localparam logic signed [FIELD_W-1:0] COMP_EDGE = FIELD_W'(1 << (IN_WIDTH - 1));

   typedef struct {
      logic signed [FIELD_W-1:0] sin_val;
      logic signed [FIELD_W-1:0] cos_val;
      bit                        typed;   // angle below is known at a glance
      logic signed [OUT_W-1:0]   angle;
   } vec_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [FIELD_W-1:0] req_sin_val;
   logic signed [FIELD_W-1:0] req_cos_val;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [OUT_W-1:0]   rsp_angle;

   // typed angle travels with the word, updated on the same edge as the payload
   bit                        held_typed;
   logic signed [OUT_W-1:0]   held_angle;

   logic signed [OUT_W-1:0]   angle_expect_q[$];
   int                        err_count;
   int                        stall_cycles;
   bit                        quiet_run;
   bit                        rsp_hold_req;

   vec_row_type corner_rows [25] = '{
      '{'0,         '0,         1'b1,  12'sd0},
      '{'0,         COMP_MAX,   1'b1,  12'sd0},
      '{'0,         -COMP_MAX,  1'b1,  12'sd1024},
      '{'0,         -24'sd1,    1'b1,  12'sd1024},
      '{COMP_MAX,   '0,         1'b1,  12'sd512},
      '{-COMP_MAX,  '0,         1'b1, -12'sd512},
      '{24'sd1,     24'sd1,     1'b1,  12'sd256},
      '{24'sd1,     -24'sd1,    1'b1,  12'sd768},
      '{-24'sd1,    24'sd1,     1'b1, -12'sd256},
      '{-24'sd1,    -24'sd1,    1'b1, -12'sd768},
      '{COMP_EDGE,  '0,         1'b1, -12'sd512},
      '{'0,         COMP_EDGE,  1'b1,  12'sd1024},
      '{COMP_EDGE,  COMP_EDGE,  1'b1, -12'sd768},
      '{COMP_EDGE,  COMP_MAX,   1'b1, -12'sd256},
      '{COMP_MAX,   24'sd1,     1'b1,  12'sd512},
      '{24'sd1,     COMP_MAX,   1'b1,  12'sd0},
      '{-24'sd1,    -COMP_MAX,  1'b1, -12'sd1024},
      '{-COMP_MAX,  24'sd1,     1'b1, -12'sd512},
      '{COMP_MAX,   COMP_MAX-1, 1'b0,  12'sd0},
      '{COMP_MAX-1, COMP_MAX,   1'b0,  12'sd0},
      '{-24'sd3,    24'sd7,     1'b0,  12'sd0},
      '{24'sd100,   -24'sd37,   1'b0,  12'sd0},
      '{-24'sd12345, -24'sd54321, 1'b0, 12'sd0},
      '{24'sh555555, 24'shaaaaaa, 1'b0, 12'sd0},
      '{24'shaaaaaa, 24'sh555555, 1'b0, 12'sd0}
   };

   fast_atan2_octant DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sin_val (req_sin_val),
      .req_cos_val (req_cos_val),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_angle   (rsp_angle)
   );

   always #5 clock = ~clock;

   // angle in pi/1024 units: min*256/max, then mirrored into the octant
   function automatic logic signed [OUT_W-1:0] atan_predict(
      input logic signed [FIELD_W-1:0] sin_word,
      input logic signed [FIELD_W-1:0] cos_word
   );
      logic signed [IN_WIDTH-1:0] y_used;
      logic signed [IN_WIDTH-1:0] x_used;
      longint y, x, ay, ax, lo, hi, est, lim;
      y_used = sin_word[IN_WIDTH-1:0];
      x_used = cos_word[IN_WIDTH-1:0];
      y      = y_used;
      x      = x_used;
      lim    = (longint'(1) << (IN_WIDTH - 1)) - 1;
      // most negative code saturates
      if (y < -lim) y = -lim;
      if (x < -lim) x = -lim;
      if (x == 0 && y == 0) return '0;
      ay  = (y < 0) ? -y : y;
      ax  = (x < 0) ? -x : x;
      lo  = (ay < ax) ? ay : ax;
      hi  = (ay > ax) ? ay : ax;
      est = (lo * 256) / hi;
      if (ay > ax) est = 512 - est;
      if (x < 0)   est = 1024 - est;
      if (y < 0)   est = -est;
      return est[OUT_W-1:0];
   endfunction

   function automatic logic signed [FIELD_W-1:0] rand_component();
      int unsigned pick;
      logic signed [FIELD_W-1:0] v;
      pick = $urandom_range(99);
      if (pick < 40)      v = FIELD_W'($urandom);
      else if (pick < 60) v = FIELD_W'($urandom_range(32) - 16);
      else if (pick < 68) v = '0;
      else if (pick < 72) v = COMP_EDGE;
      else if (pick < 76) v = $urandom_range(1) ? COMP_MAX : -COMP_MAX;
      else begin
         v = FIELD_W'($urandom >> $urandom_range(23, 8));
         if ($urandom_range(1)) v = -v;
      end
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      if (err_count < 100) $display("mismatch at %0t: %s", $time, msg);
      err_count++;
   endtask

   // hold the word until it is taken
   task automatic offer_pair(
      input logic signed [FIELD_W-1:0] sin_word,
      input logic signed [FIELD_W-1:0] cos_word,
      input bit                        typed,
      input logic signed [OUT_W-1:0]   angle
   );
      req_valid   <= 1'b1;
      req_sin_val <= sin_word;
      req_cos_val <= cos_word;
      held_typed  <= typed;
      held_angle  <= angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic sender_gap();
      if (!quiet_run && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_run || ($urandom_range(99) >= 24);
         end
      end
   end

   // check each angle word against the oldest expectation, then queue new ones
   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (angle_expect_q.size() == 0) begin
               report_mismatch($sformatf("angle %0d with nothing expected", rsp_angle));
            end else begin
               want = angle_expect_q.pop_front();
               if (rsp_angle !== want)
                  report_mismatch($sformatf("angle got %0d want %0d", rsp_angle, want));
            end
         end
         if (req_valid && req_ready) begin
            want = held_typed ? held_angle : atan_predict(req_sin_val, req_cos_val);
            angle_expect_q.push_back(want);
         end
      end
   end

   // watchdog: cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("fast_atan2_octant verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : req_side
      logic signed [FIELD_W-1:0] s;
      logic signed [FIELD_W-1:0] c;
      int unsigned m;
      int unsigned m2;
      clock        = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_sin_val  <= '0;
      req_cos_val  <= '0;
      held_typed   <= 1'b0;
      held_angle   <= '0;
      err_count    = 0;
      quiet_run    = 1'b0;
      rsp_hold_req = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // corner vectors
      foreach (corner_rows[i]) begin
         offer_pair(corner_rows[i].sin_val, corner_rows[i].cos_val,
                    corner_rows[i].typed, corner_rows[i].angle);
         sender_gap();
      end

      // random vector pairs
      for (int n = 0; n < RAND_WORDS; n++) begin
         if (n == HOLD_AT) rsp_hold_req = 1'b1;
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            while (angle_expect_q.size() != 0) @(posedge clock);
         end
         quiet_run = (n >= QUIET_FROM) && (n < QUIET_TO);
         if ($urandom_range(99) < 20) begin
            // nearly equal magnitudes, around the octant boundary
            m  = $urandom_range(COMP_MAX - 1, 2);
            m2 = m + $urandom_range(2) - 1;
            s  = FIELD_W'(m);
            c  = FIELD_W'(m2);
            if ($urandom_range(1)) s = -s;
            if ($urandom_range(1)) c = -c;
         end else begin
            s = rand_component();
            c = rand_component();
         end
         offer_pair(s, c, 1'b0, '0);
         sender_gap();
      end
      quiet_run = 1'b0;
      req_valid <= 1'b0;

      while (angle_expect_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_count == 0 && angle_expect_q.size() == 0) begin
         $display("fast_atan2_octant verification clean");
      end else begin
         $display("fast_atan2_octant verification failed");
      end
      $finish;
   end

endmodule
